FILE: hdl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared widths, defaults and controller/datapath command types for the
// additive square suffix checker.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int SYMBOL_W        = 8;
  localparam int WORD_LEN_W      = 9;
  localparam int MAX_LEN_DEF     = 256;
  localparam int SYMBOL_BITS_DEF = 8;

  typedef struct packed {
    logic accept;
    logic issue;
    logic publish;
  } asc_cmd_t;

  typedef struct packed {
    logic more;
  } asc_sts_t;

endpackage

FILE: hdl/asc_in_if.sv
// ----------------------------------------------------------------------------
// asc_in_if
// Symbol request channel: valid/ready handshake with symbol and start flag.
// ----------------------------------------------------------------------------
interface asc_in_if import asc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                start_word;

  modport source (output valid, output symbol, output start_word, input ready);
  modport sink   (input valid, input symbol, input start_word, output ready);
endinterface

FILE: hdl/asc_out_if.sv
// ----------------------------------------------------------------------------
// asc_out_if
// Result channel: valid/ready handshake with check result and word length.
// ----------------------------------------------------------------------------
interface asc_out_if import asc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  square_free;
  logic                  overflow;
  logic [WORD_LEN_W-1:0] word_len;

  modport source (output valid, output square_free, output overflow, output word_len,
                  input ready);
  modport sink   (input valid, input square_free, input overflow, input word_len,
                  output ready);
endinterface

FILE: hdl/asc_ctrl.sv
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer: accepts a symbol, steps the block-length scan, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module asc_ctrl import asc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  asc_sts_t sts_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output asc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue   = (state_q == ST_SCAN) && sts_i.more;
    cmd_o.publish = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!sts_i.more) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (cmd_o.publish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/asc_dp.sv
// ----------------------------------------------------------------------------
// asc_dp
// Datapath: prefix-sum memory, word length, scan counter, two-port read and
// the 2*P[len-i] == P[len] + P[len-2i] compare, plus the result register.
// ----------------------------------------------------------------------------
module asc_dp import asc_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  asc_cmd_t              cmd_i,
  input  logic [SYMBOL_W-1:0]   symbol_i,
  input  logic                  start_word_i,
  output asc_sts_t              sts_o,
  output logic                  square_free_o,
  output logic                  overflow_o,
  output logic [WORD_LEN_W-1:0] word_len_o
);

  localparam int SYM_W = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = SYM_W + AW;
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_LEN);

  logic [SUM_W-1:0] mem [MAX_LEN];

  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] i_q;
  logic [SUM_W-1:0] top_q;
  logic             ovf_q;
  logic             hit_q;
  logic             rd_vld_q;
  logic             zb_q;
  logic [SUM_W-1:0] pa_q;
  logic [SUM_W-1:0] pb_q;

  logic [LEN_W-1:0] len_eff;
  logic [SUM_W-1:0] top_eff;
  logic [SUM_W-1:0] sum_new;
  logic             full;
  logic [LEN_W-1:0] half;
  logic [LEN_W-1:0] addr_a;
  logic [LEN_W-1:0] addr_b;
  logic [LEN_W-1:0] idx_a;
  logic [LEN_W-1:0] idx_b;
  logic [SUM_W-1:0] pb_eff;
  logic             match;
  logic [31:0]      len_ext;

  assign len_eff = start_word_i ? '0 : len_q;
  assign top_eff = start_word_i ? '0 : top_q;
  assign sum_new = top_eff + SUM_W'(symbol_i[SYM_W-1:0]);
  assign full    = (len_eff >= LenMax);

  assign half    = len_q >> 1;
  assign addr_a  = len_q - i_q;
  assign addr_b  = len_q - (i_q << 1);
  assign idx_a   = addr_a - 1'b1;
  assign idx_b   = addr_b - 1'b1;
  assign sts_o.more = (i_q <= half);

  assign pb_eff  = zb_q ? '0 : pb_q;
  assign match   = ({pa_q, 1'b0} == ({1'b0, top_q} + {1'b0, pb_eff}));
  assign len_ext = 32'(len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !full) begin
      mem[len_eff[AW-1:0]] <= sum_new;
    end
    if (cmd_i.issue) begin
      pa_q <= mem[idx_a[AW-1:0]];
      pb_q <= mem[idx_b[AW-1:0]];
      zb_q <= (addr_b == '0);
    end
    if (cmd_i.publish) begin
      square_free_o <= !hit_q;
      overflow_o    <= ovf_q;
      word_len_o    <= len_ext[WORD_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      top_q    <= '0;
      i_q      <= '0;
      ovf_q    <= 1'b0;
      hit_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.accept) begin
        i_q   <= LEN_W'(1);
        hit_q <= 1'b0;
        if (full) begin
          len_q <= len_eff;
          ovf_q <= 1'b1;
        end else begin
          len_q <= len_eff + 1'b1;
          top_q <= sum_new;
          ovf_q <= 1'b0;
        end
      end else begin
        if (cmd_i.issue) begin
          i_q <= i_q + 1'b1;
        end
        if (rd_vld_q && match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/additive_square_suffix_check.sv
// ----------------------------------------------------------------------------
// additive_square_suffix_check
// Appends one symbol per request to a stored word (a request on a full word sets
// overflow instead) and reports whether an additive square ends at its last symbol.
// ----------------------------------------------------------------------------
// Scan: after accept, one block length is compared per cycle over the two-port
// prefix-sum memory, for block lengths 1 to floor(len/2) (len after the symbol);
// the sequencer then waits in ST_FIN until the output register is free and loads it.
// Throughput: one symbol in flight; the next is taken while a result waits.
// Reset: word empty, no result pending; memory contents are not cleared.
module additive_square_suffix_check import asc_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  asc_in_if.sink     in_i,
  asc_out_if.source  out_o
);

  asc_cmd_t cmd;
  asc_sts_t sts;

  asc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  asc_dp #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_i      (in_i.symbol),
    .start_word_i  (in_i.start_word),
    .sts_o         (sts),
    .square_free_o (out_o.square_free),
    .overflow_o    (out_o.overflow),
    .word_len_o    (out_o.word_len)
  );

  a_no_accept_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !in_i.ready)
    else $error("request taken during scan");

  a_publish_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_o.valid)
    else $error("result not presented after publish");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready held after accept");

  a_publish_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !cmd.issue && !cmd.accept)
    else $error("overlapping commands");

endmodule
